// ----- src/mtg_pkg.sv -----
// mtg_pkg: shared types and constants for the mt19937 generator core
// no dependencies; imported by the interfaces, controller, datapath and top level
package mtg_pkg;

  localparam int N       = 624;
  localparam int M       = 397;
  localparam int WORD_W  = 32;
  localparam int IDX_W   = 10;
  localparam int REQ_W   = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam word_t TWIST_XOR    = 32'h9908b0df;
  localparam word_t HI_BIT       = 32'h80000000;
  localparam word_t LO_BITS      = 32'h7fffffff;
  localparam word_t TEMPER_B     = 32'h9d2c5680;
  localparam word_t TEMPER_C     = 32'hefc60000;
  localparam word_t LCG_MUL      = 32'd69069;
  localparam word_t DEFAULT_SEED = 32'd4357;
  localparam word_t HALF_MASK    = 32'hffff0000;

  localparam idx_t POS_REGEN    = idx_t'(N);
  localparam idx_t POS_UNSEEDED = idx_t'(N + 1);
  localparam idx_t IDX_LAST     = idx_t'(N - 1);
  localparam idx_t IDX_M        = idx_t'(M);
  localparam idx_t IDX_WRAP     = idx_t'(N - M);

  typedef enum logic [REQ_W-1:0] {
    REQ_DRAW   = 2'd0,
    REQ_RESEED = 2'd1,
    REQ_LOAD   = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_TW_PRIME,
    ST_TW_RUN,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } state_t;

  typedef enum logic [1:0] {
    WR_LOAD,
    WR_FILL,
    WR_TWIST
  } wr_src_t;

  typedef struct packed {
    logic    we;
    wr_src_t wr_src;
    idx_t    wr_addr;
    logic    rd_en;
    idx_t    rd_a_addr;
    idx_t    rd_b_addr;
    logic    cur_shift;
    logic    seed_load;
    logic    seed_default;
    logic    seed_step;
    logic    hi_capture;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// ----- src/mtg_if.sv -----
// mtg_in_if / mtg_out_if: valid/ready channels for requests and random words
// depends on mtg_pkg for field widths
interface mtg_in_if
  import mtg_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [WORD_W-1:0]   seed_value;
  logic [IDX_W-1:0]    load_index;
  logic [WORD_W-1:0]   load_word;

  modport source (output valid, req_type, seed_value, load_index, load_word, input ready);
  modport sink   (input valid, req_type, seed_value, load_index, load_word, output ready);
endinterface

interface mtg_out_if
  import mtg_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, random_word, input ready);
  modport sink   (input valid, random_word, output ready);
endinterface

// ----- src/mtg_dp.sv -----
// mtg_dp: state word memory, seed lcg, twist and tempering datapath, output register
// depends on mtg_pkg; driven by mtg_ctrl through dp_cmd_t
module mtg_dp
  import mtg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  word_t    seed_value,
  input  word_t    load_word,
  output logic     out_valid,
  input  logic     out_ready,
  output word_t    out_word
);

  word_t mem [N];
  word_t rd_a_r;
  word_t rd_b_r;
  word_t cur_r;
  word_t seed_r;
  word_t seed_nxt;
  logic [WORD_W/2-1:0] hi_r;
  word_t twist_y;
  word_t twist_word;
  word_t wr_data;
  word_t temper_word;
  word_t out_word_r;
  logic  out_valid_r;

  function automatic word_t temper(input word_t x);
    word_t y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  assign seed_nxt   = word_t'(seed_r * LCG_MUL + 32'd1);
  assign twist_y    = (cur_r & HI_BIT) | (rd_a_r & LO_BITS);
  assign twist_word = rd_b_r ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_XOR : '0);
  assign temper_word = temper(rd_a_r);

  always_comb begin
    case (cmd.wr_src)
      WR_LOAD:  wr_data = load_word;
      WR_FILL:  wr_data = {hi_r, seed_r[WORD_W-1:WORD_W/2]};
      WR_TWIST: wr_data = twist_word;
      default:  wr_data = load_word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem[cmd.rd_a_addr];
      rd_b_r <= mem[cmd.rd_b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cur_shift) begin
      cur_r <= rd_a_r;
    end
    if (cmd.seed_load) begin
      seed_r <= cmd.seed_default ? DEFAULT_SEED : seed_value;
    end else if (cmd.seed_step) begin
      seed_r <= seed_nxt;
    end
    if (cmd.hi_capture) begin
      hi_r <= seed_r[WORD_W-1:WORD_W/2];
    end
    if (cmd.out_load) begin
      out_word_r <= temper_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;

endmodule

// ----- src/mtg_ctrl.sv -----
// mtg_ctrl: request sequencer for seeding, regeneration and draws
// depends on mtg_pkg; commands mtg_dp through dp_cmd_t
module mtg_ctrl
  import mtg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [REQ_W-1:0] req_type,
  input  idx_t     load_index,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  idx_t   k_r, k_nxt;
  logic   phase_r, phase_nxt;
  idx_t   pos_r, pos_nxt;
  logic   draw_pend_r, draw_pend_nxt;
  logic   accept;
  logic   is_draw, is_reseed, is_load_ok;

  assign accept     = in_valid && (state_r == ST_IDLE);
  assign is_draw    = (req_type == REQ_DRAW);
  assign is_reseed  = (req_type == REQ_RESEED);
  assign is_load_ok = (req_type == REQ_LOAD) && (load_index < POS_REGEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      phase_r     <= 1'b0;
      pos_r       <= POS_UNSEEDED;
      draw_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      draw_pend_r <= draw_pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_draw) begin
          if (pos_r == POS_UNSEEDED) begin
            state_nxt = ST_FILL;
          end else if (pos_r == POS_REGEN) begin
            state_nxt = ST_TW_PRIME;
          end else begin
            state_nxt = ST_DRAW_RD;
          end
        end else if (accept && is_reseed) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (phase_r && (k_r == IDX_LAST)) begin
          state_nxt = draw_pend_r ? ST_TW_PRIME : ST_IDLE;
        end
      end
      ST_TW_PRIME: state_nxt = ST_TW_RUN;
      ST_TW_RUN: begin
        if (k_r == POS_REGEN) begin
          state_nxt = ST_DRAW_RD;
        end
      end
      ST_DRAW_RD:  state_nxt = ST_DRAW_OUT;
      ST_DRAW_OUT: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    k_nxt         = k_r;
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    draw_pend_nxt = draw_pend_r;
    case (state_r)
      ST_IDLE: begin
        k_nxt     = '0;
        phase_nxt = 1'b0;
        if (accept) begin
          if (is_draw) begin
            draw_pend_nxt = 1'b1;
          end else if (is_reseed) begin
            draw_pend_nxt = 1'b0;
          end else if (is_load_ok) begin
            pos_nxt = POS_REGEN;
          end
        end
      end
      ST_FILL: begin
        phase_nxt = ~phase_r;
        if (phase_r) begin
          if (k_r == IDX_LAST) begin
            k_nxt   = '0;
            pos_nxt = POS_REGEN;
          end else begin
            k_nxt = k_r + idx_t'(1);
          end
        end
      end
      ST_TW_PRIME: k_nxt = '0;
      ST_TW_RUN: begin
        k_nxt = k_r + idx_t'(1);
        if (k_r == POS_REGEN) begin
          k_nxt   = '0;
          pos_nxt = '0;
        end
      end
      ST_DRAW_RD: begin
      end
      ST_DRAW_OUT: begin
        if (stat.out_free) begin
          pos_nxt = pos_r + idx_t'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.wr_src = WR_LOAD;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (is_reseed) begin
            cmd.seed_load = 1'b1;
          end else if (is_draw && (pos_r == POS_UNSEEDED)) begin
            cmd.seed_load    = 1'b1;
            cmd.seed_default = 1'b1;
          end else if (is_load_ok) begin
            cmd.we      = 1'b1;
            cmd.wr_src  = WR_LOAD;
            cmd.wr_addr = load_index;
          end
        end
      end
      ST_FILL: begin
        cmd.seed_step = 1'b1;
        if (!phase_r) begin
          cmd.hi_capture = 1'b1;
        end else begin
          cmd.we      = 1'b1;
          cmd.wr_src  = WR_FILL;
          cmd.wr_addr = k_r;
        end
      end
      ST_TW_PRIME: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_a_addr = '0;
        cmd.rd_b_addr = '0;
      end
      ST_TW_RUN: begin
        cmd.cur_shift = 1'b1;
        cmd.rd_en     = (k_r != POS_REGEN);
        cmd.rd_a_addr = (k_r == IDX_LAST) ? '0 : k_r + idx_t'(1);
        cmd.rd_b_addr = (k_r < IDX_WRAP) ? k_r + IDX_M : k_r - IDX_WRAP;
        cmd.we        = (k_r != '0);
        cmd.wr_src    = WR_TWIST;
        cmd.wr_addr   = k_r - idx_t'(1);
      end
      ST_DRAW_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_a_addr = pos_r;
        cmd.rd_b_addr = pos_r;
      end
      ST_DRAW_OUT: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/mersenne_twister_generator_core.sv -----
// mersenne_twister_generator_core: 32-bit mt19937 generator with 69069 seeding
// draw with words left: ram read in ST_DRAW_RD, tempered word registered in ST_DRAW_OUT once out is free
// draw that needs regeneration: twist pass first (ST_TW_PRIME, ST_TW_RUN), one twisted word per cycle on a 2-read ram
// reseed: fill pass, one lcg multiply per cycle; a first draw runs the fill before regen
// load: ram write on accept; reset clears control only, position marked unseeded, ram not cleared
module mersenne_twister_generator_core
  import mtg_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  mtg_in_if.sink   in_ch,
  mtg_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mtg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .req_type   (in_ch.req_type),
    .load_index (in_ch.load_index),
    .stat       (stat),
    .cmd        (cmd)
  );

  mtg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .seed_value (in_ch.seed_value),
    .load_word  (in_ch.load_word),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_word   (out_ch.random_word)
  );

endmodule
